[sv/multi_voice_sine_pan_mixer_macros.svh]
// ----------------------------------------------------------------------------
// multi_voice_sine_pan_mixer_macros
// Assertion macros shared by the mixer modules. Each expects clk, and
// MVSP_ASSERT also arst_n, in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_SINE_PAN_MIXER_MACROS_SVH
`define MULTI_VOICE_SINE_PAN_MIXER_MACROS_SVH

// checked only while out of reset
`define MVSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked on every edge, reset included
`define MVSP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

[sv/mvsp_pkg.sv]
// ----------------------------------------------------------------------------
// mvsp_pkg
// Types, register codes and the quarter-wave sine entry function of the
// multi-voice sine pan mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvsp_pkg;

	// configuration port
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_INDEX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN          = 3'd4;

	localparam int unsigned COUNT_W = 4;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned PAN_W   = 17;
	localparam logic [PAN_W-1:0] PAN_ONE = 17'h10000;

	// signed sample times signed pan operand
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned PROD_W   = 34;

	// quarter-wave table entry math
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_DRAIN,
		ST_DIVIDE,
		ST_EMIT
	} mix_state_t;

	// controls fanned out to every voice cell
	typedef struct packed {
		logic             shift;
		logic             clear;
		logic             wr_step;
		logic             wr_offset;
		logic             wr_pan;
		logic [CFG_W-1:0] wdata;
	} cell_ctrl_t;

	// sin(pi/2 * idx / 2^tbits) in Q1.15 from a Q30 taylor series
	function automatic logic [14:0] sine_entry(input int unsigned idx,
			input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		longint      r;
		x    = (64'(idx) * HALF_PI_Q30) >> tbits;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		return r[14:0];
	endfunction

endpackage

`default_nettype wire

[sv/mvsp_cell.sv]
// ----------------------------------------------------------------------------
// mvsp_cell
// One voice of the oscillator ring: phase accumulator, step, offset and pan.
// Hands its whole voice to the neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsp_cell #(
	parameter int unsigned PHASE_BITS = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  mvsp_pkg::cell_ctrl_t      ctrl,
	input  wire                       sel,
	input  wire  [PHASE_BITS-1:0]     acc_in,
	input  wire  [PHASE_BITS-1:0]     step_in,
	input  wire  [PHASE_BITS-1:0]     off_in,
	input  wire  [mvsp_pkg::PAN_W-1:0] pan_in,
	output logic [PHASE_BITS-1:0]     acc,
	output logic [PHASE_BITS-1:0]     step,
	output logic [PHASE_BITS-1:0]     off,
	output logic [mvsp_pkg::PAN_W-1:0] pan
);
	import mvsp_pkg::*;

	logic [PHASE_BITS-1:0] acc_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [PHASE_BITS-1:0] off_q;
	logic [PAN_W-1:0]      pan_q;

	// accumulator: restart clears, shift takes the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.shift) begin
			acc_q <= acc_in;
		end
	end

	// voice settings: shift or register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			off_q  <= '0;
			pan_q  <= '0;
		end else if (ctrl.shift) begin
			step_q <= step_in;
			off_q  <= off_in;
			pan_q  <= pan_in;
		end else if (sel) begin
			if (ctrl.wr_step) begin
				step_q <= PHASE_BITS'(ctrl.wdata);
			end
			if (ctrl.wr_offset) begin
				off_q <= PHASE_BITS'(ctrl.wdata);
			end
			if (ctrl.wr_pan) begin
				pan_q <= ctrl.wdata[PAN_W-1:0];
			end
		end
	end

	assign acc  = acc_q;
	assign step = step_q;
	assign off  = off_q;
	assign pan  = pan_q;

endmodule

`default_nettype wire

[sv/mvsp_sine.sv]
// ----------------------------------------------------------------------------
// mvsp_sine
// Phase to sine: quadrant fold and registered quarter-wave table read.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsp_sine #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned TABLE_BITS = 10
) (
	input  wire                               clk,
	input  wire  [PHASE_BITS-1:0]             phase,
	output logic signed [mvsp_pkg::SAMPLE_W-1:0] sample
);
	import mvsp_pkg::*;

	localparam int unsigned TBL_N = 1 << TABLE_BITS;

	logic [14:0]           table_w [0:TBL_N];
	logic [1:0]            quad_c;
	logic [TABLE_BITS-1:0] q_c;
	logic [TABLE_BITS:0]   addr_c;
	logic [14:0]           mag_q;
	logic                  neg_q;

	// constant quarter-wave table, entries 0 through N
	for (genvar g = 0; g <= TBL_N; g++) begin : g_tbl
		assign table_w[g] = sine_entry(g, TABLE_BITS);
	end

	// odd quadrants read the table mirrored
	always_comb begin
		quad_c = phase[PHASE_BITS-1 -: 2];
		q_c    = phase[PHASE_BITS-3 -: TABLE_BITS];
		if (quad_c[0]) begin
			addr_c = (TABLE_BITS+1)'(TBL_N) - {1'b0, q_c};
		end else begin
			addr_c = {1'b0, q_c};
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= table_w[addr_c];
		neg_q <= quad_c[1];
	end

	// lower half of the wave is negated
	assign sample = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

`default_nettype wire

[sv/mvsp_div.sv]
// ----------------------------------------------------------------------------
// mvsp_div
// Serial mix divider: sum / (count * 65536) truncated toward zero and
// saturated to Q1.15, zero for a zero count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_voice_sine_pan_mixer_macros.svh"

module mvsp_div #(
	parameter int unsigned ACC_W = 37,
	parameter int unsigned CNT_W = 4
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  signed [ACC_W-1:0]           sum,
	input  wire  [CNT_W-1:0]                  n,
	output logic                              done,
	output logic signed [mvsp_pkg::SAMPLE_W-1:0] result
);
	import mvsp_pkg::*;

	localparam int unsigned MAG_W = ACC_W - 16;
	localparam int unsigned CW    = $clog2(MAG_W + 1);

	logic [ACC_W-1:0] abs_c;
	logic [CNT_W:0]   rem_sh_c;
	logic             ge_c;
	logic [CNT_W:0]   rem_sub_c;
	logic [MAG_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] n_q;
	logic             neg_q;
	logic             zero_q;
	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;

	// magnitude of the sum and one restoring step
	always_comb begin
		abs_c     = sum[ACC_W-1] ? (~sum + 1'b1) : sum;
		rem_sh_c  = {rem_q, dvd_q[MAG_W-1]};
		ge_c      = rem_sh_c >= {1'b0, n_q};
		rem_sub_c = ge_c ? (rem_sh_c - {1'b0, n_q}) : rem_sh_c;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(MAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= abs_c[ACC_W-1:16];
			rem_q  <= '0;
			n_q    <= n;
			neg_q  <= sum[ACC_W-1];
			zero_q <= (n == '0);
		end else if (run_q) begin
			dvd_q <= {dvd_q[MAG_W-2:0], ge_c};
			rem_q <= rem_sub_c[CNT_W-1:0];
		end
	end

	// sign and saturation
	always_comb begin
		if (zero_q) begin
			result = '0;
		end else if (neg_q) begin
			if (dvd_q > MAG_W'(32768)) begin
				result = 16'sh8000;
			end else begin
				result = SAMPLE_W'(~dvd_q + 1'b1);
			end
		end else begin
			if (dvd_q > MAG_W'(32767)) begin
				result = 16'sh7FFF;
			end else begin
				result = SAMPLE_W'(dvd_q);
			end
		end
	end

	assign done = done_q;

	`MVSP_ASSERT_ALWAYS(a_run_count, run_q |-> cnt_q != '0, "divider running with no bits left")
	`MVSP_ASSERT(a_start_runs, start |=> run_q, "divider did not start")
	`MVSP_ASSERT(a_done_stops, done_q |-> !run_q, "divider done while still running")

endmodule

`default_nettype wire

[sv/multi_voice_sine_pan_mixer.sv]
// ----------------------------------------------------------------------------
// multi_voice_sine_pan_mixer
// Bank of sine oscillators with per-voice pan, mixed to one stereo pair.
// ----------------------------------------------------------------------------
// Each input transaction asks for frame_count stereo frames (capped at
// MAX_BURST) and may first restart every voice at phase zero; a request
// with no frames only applies the restart. The voices live in a ring of
// NUM_VOICES cells that rotates once per frame, passing each voice in turn
// through one shared quarter-wave table and pan multiplier. A frame takes
// a turn of the ring, a drain of the three pipeline stages before the
// dividers start, the serial mix divider (one quotient bit a cycle) and
// the output register load, and it waits on any stall of the frame channel.
// A new request is taken once the last frame of the previous one is in the
// output register. Registers are to be written only while idle; the block
// itself does not enforce it. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_voice_sine_pan_mixer_macros.svh"

module multi_voice_sine_pan_mixer #(
	parameter int unsigned NUM_VOICES = 8,
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned TABLE_BITS = 10,
	parameter int unsigned MAX_BURST  = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration
	input  wire                                 cfg_we,
	input  wire  [mvsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [mvsp_pkg::CFG_W-1:0]          cfg_wdata,
	// request channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [6:0]                          frame_count,
	input  wire                                 restart,
	// frame channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [mvsp_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [mvsp_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                last_frame
);
	import mvsp_pkg::*;

	localparam int unsigned VI_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_VOICES + 1);
	localparam int unsigned FR_W  = $clog2(MAX_BURST + 1);
	localparam int unsigned ACC_W = 33 + $clog2(NUM_VOICES + 1);

	mix_state_t state_q, state_d;

	logic [COUNT_W-1:0] voice_count_q;
	logic [INDEX_W-1:0] voice_index_q;
	logic [CNT_W-1:0]   n_c;
	logic [FR_W-1:0]    frames_c;
	logic [FR_W-1:0]    frames_left_q;
	logic [VI_W-1:0]    rot_q;

	logic in_acc;
	logic out_free;
	logic shift_c;
	logic div_start_c;
	logic load_out_c;
	logic pipe_empty_c;
	logic div_done_l;
	logic div_done_r;

	cell_ctrl_t ctrl_c;

	logic [PHASE_BITS-1:0] acc_w  [NUM_VOICES];
	logic [PHASE_BITS-1:0] step_w [NUM_VOICES];
	logic [PHASE_BITS-1:0] off_w  [NUM_VOICES];
	logic [PAN_W-1:0]      pan_w  [NUM_VOICES];
	logic [PHASE_BITS-1:0] acc_wrap_c;

	logic [PHASE_BITS-1:0]     phase_s1;
	logic [PAN_W-1:0]          pan_s1;
	logic                      act_s1;
	logic                      v_s1;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic [PAN_W-1:0]          pan_s2;
	logic                      act_s2;
	logic                      v_s2;
	logic signed [PROD_W-1:0]  prod_l_s3;
	logic signed [PROD_W-1:0]  prod_r_s3;
	logic                      act_s3;
	logic                      v_s3;
	logic signed [ACC_W-1:0]   sum_l_q;
	logic signed [ACC_W-1:0]   sum_r_q;

	logic signed [SAMPLE_W-1:0] res_l;
	logic signed [SAMPLE_W-1:0] res_r;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       last_q;

	// handshake terms
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// active voices and burst length after clamping
	assign n_c = CNT_W'((32'(voice_count_q) > NUM_VOICES) ? NUM_VOICES
		: 32'(voice_count_q));
	assign frames_c = (32'(frame_count) > MAX_BURST) ? FR_W'(MAX_BURST)
		: FR_W'(frame_count);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_count_q <= '0;
			voice_index_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOICE_COUNT: voice_count_q <= cfg_wdata[COUNT_W-1:0];
				REG_VOICE_INDEX: voice_index_q <= cfg_wdata[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// controls to the cells
	always_comb begin
		ctrl_c.shift     = shift_c;
		ctrl_c.clear     = in_acc && restart;
		ctrl_c.wr_step   = cfg_we && (cfg_index == REG_PHASE_STEP);
		ctrl_c.wr_offset = cfg_we && (cfg_index == REG_PHASE_OFFSET);
		ctrl_c.wr_pan    = cfg_we && (cfg_index == REG_PAN);
		ctrl_c.wdata     = cfg_wdata;
	end

	// head voice advances as it wraps to the tail
	assign acc_wrap_c = acc_w[0] + step_w[0];

	// ring of voice cells, cell 0 is the head
	for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
		logic [PHASE_BITS-1:0] acc_in_w;
		logic [PHASE_BITS-1:0] step_in_w;
		logic [PHASE_BITS-1:0] off_in_w;
		logic [PAN_W-1:0]      pan_in_w;
		logic                  sel_w;

		if (g == NUM_VOICES - 1) begin : g_tail
			assign acc_in_w  = acc_wrap_c;
			assign step_in_w = step_w[0];
			assign off_in_w  = off_w[0];
			assign pan_in_w  = pan_w[0];
		end else begin : g_mid
			assign acc_in_w  = acc_w[g+1];
			assign step_in_w = step_w[g+1];
			assign off_in_w  = off_w[g+1];
			assign pan_in_w  = pan_w[g+1];
		end

		assign sel_w = (32'(voice_index_q) == g);

		mvsp_cell #(
			.PHASE_BITS(PHASE_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl_c),
			.sel    (sel_w),
			.acc_in (acc_in_w),
			.step_in(step_in_w),
			.off_in (off_in_w),
			.pan_in (pan_in_w),
			.acc    (acc_w[g]),
			.step   (step_w[g]),
			.off    (off_w[g]),
			.pan    (pan_w[g])
		);
	end

	// stage 1: phase of the head voice, clamped pan
	always_ff @(posedge clk) begin
		phase_s1 <= acc_w[0] + off_w[0];
		pan_s1   <= pan_w[0][PAN_W-1] ? PAN_ONE : pan_w[0];
		act_s1   <= 32'(rot_q) < 32'(n_c);
	end

	// stage 2: table read
	mvsp_sine #(
		.PHASE_BITS(PHASE_BITS),
		.TABLE_BITS(TABLE_BITS)
	) u_sine (
		.clk   (clk),
		.phase (phase_s1),
		.sample(sample_s2)
	);

	always_ff @(posedge clk) begin
		pan_s2 <= pan_s1;
		act_s2 <= act_s1;
	end

	// stage 3: pan products
	always_ff @(posedge clk) begin
		prod_l_s3 <= sample_s2 * $signed({1'b0, pan_s2});
		prod_r_s3 <= sample_s2 * $signed({1'b0, PAN_ONE - pan_s2});
		act_s3    <= act_s2;
	end

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= shift_c;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign pipe_empty_c = !(v_s1 || v_s2 || v_s3);

	// stage 4: channel sums, cleared as the divider takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (div_start_c) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (v_s3 && act_s3) begin
			sum_l_q <= sum_l_q + ACC_W'(prod_l_s3);
			sum_r_q <= sum_r_q + ACC_W'(prod_r_s3);
		end
	end

	// mix dividers, one per channel
	mvsp_div #(
		.ACC_W(ACC_W),
		.CNT_W(CNT_W)
	) u_div_l (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_c),
		.sum   (sum_l_q),
		.n     (n_c),
		.done  (div_done_l),
		.result(res_l)
	);

	mvsp_div #(
		.ACC_W(ACC_W),
		.CNT_W(CNT_W)
	) u_div_r (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_c),
		.sum   (sum_r_q),
		.n     (n_c),
		.done  (div_done_r),
		.result(res_r)
	);

	// frame sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (frames_c != '0)) begin
					state_d = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				if (rot_q == VI_W'(NUM_VOICES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty_c) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done_l) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (frames_left_q == FR_W'(1)) ? ST_IDLE : ST_ROTATE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// frame sequencer: outputs
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		shift_c     = (state_q == ST_ROTATE);
		div_start_c = (state_q == ST_DRAIN) && pipe_empty_c;
		load_out_c  = (state_q == ST_EMIT) && out_free;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frames_left_q <= '0;
			rot_q         <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				frames_left_q <= frames_c;
			end else if (load_out_c) begin
				frames_left_q <= frames_left_q - 1'b1;
			end
			if (shift_c) begin
				rot_q <= (rot_q == VI_W'(NUM_VOICES - 1)) ? '0 : rot_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out_c) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_c) begin
			left_q  <= res_l;
			right_q <= res_r;
			last_q  <= (frames_left_q == FR_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign last_frame   = last_q;

	`MVSP_ASSERT(a_idle_empty, (state_q == ST_IDLE) |-> pipe_empty_c, "idle with voices in flight")
	`MVSP_ASSERT(a_rot_range, shift_c |-> 32'(rot_q) < NUM_VOICES, "ring position out of range")
	`MVSP_ASSERT(a_load_frames, load_out_c |-> frames_left_q != '0, "frame emitted past burst end")
	`MVSP_ASSERT(a_div_sync, div_done_l == div_done_r, "channel dividers out of step")
	`MVSP_ASSERT(a_done_state, div_done_l |-> state_q == ST_DIVIDE, "divider done outside divide")

endmodule

`default_nettype wire

[dv/multi_voice_sine_pan_mixer_tb.sv]
// ----------------------------------------------------------------------------
// multi_voice_sine_pan_mixer_tb
// Self-checking bench for the sine oscillator bank with stereo pan mixing.
// Frame requests go in as bursts with random gaps, and the frame channel
// stalls on its own pattern. A predictor keeps a copy of the voice table,
// phase accumulators and quarter-wave sine table. It queues the stereo
// frames that each accepted request must produce, and every returned frame
// is compared field by field. Voice settings change only between phases,
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_sine_pan_mixer_tb;

	import mvsp_pkg::*;

	localparam int unsigned VOICES          = 8;
	localparam int unsigned TBL_BITS        = 10;
	localparam int unsigned TBL_N           = 1 << TBL_BITS;
	localparam int unsigned BURST_CAP       = 64;
	localparam int unsigned SETTLE_CYCLES   = 64;
	localparam int unsigned HOLD_OFF_CYCLES = 4000;
	localparam int unsigned RANDOM_PHASES   = 12;
	localparam int unsigned ITEMS_PER_PHASE = 40;
	localparam int unsigned REPORT_LIMIT    = 10;
	localparam longint      CYCLE_LIMIT     = 10_000_000;
	// 2^32 / 44100, phase step of a 1 hz tone
	localparam logic [31:0] HZ_TO_STEP      = 32'd97391;

	// register indexes past the last defined one, written and ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
	} stereo_frame_t;

	// predicted voice bank and the queue of frames still owed by the block
	class mixer_frame_checker;
		int unsigned   sine_quarter [TBL_N+1];
		logic [31:0]   phase_acc    [VOICES];
		logic [31:0]   phase_step   [VOICES];
		logic [31:0]   phase_offset [VOICES];
		logic [16:0]   pan_share    [VOICES];
		logic [3:0]    active_voices;
		logic [2:0]    sel_voice;
		stereo_frame_t pending_frames [$];
		int unsigned   fail_count;

		function new();
			for (int unsigned i = 0; i <= TBL_N; i++) begin
				sine_quarter[i] = quarter_sine(i);
			end
			for (int unsigned v = 0; v < VOICES; v++) begin
				phase_acc[v]    = '0;
				phase_step[v]   = '0;
				phase_offset[v] = '0;
				pan_share[v]    = '0;
			end
			active_voices = '0;
			sel_voice     = '0;
			fail_count    = 0;
		endfunction

		// sin(pi/2 * i / N) in q1.15 from a truncated q30 taylor series
		function int unsigned quarter_sine(int unsigned i);
			logic [63:0] x;
			logic [63:0] term;
			longint      acc;
			longint      rounded;
			x    = (64'(i) * HALF_PI_Q30) >> TBL_BITS;
			term = x;
			acc  = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'(2 * k * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rounded = (acc + 16384) >>> 15;
			if (rounded > 32767) begin
				rounded = 32767;
			end
			return int'(rounded);
		endfunction

		// divide the weighted sum by voices times full pan, clip to q1.15
		function logic signed [SAMPLE_W-1:0] scale_to_sample(longint wsum, int unsigned n);
			longint r;
			r = wsum / (longint'(n) * 65536);
			if (r > 32767) begin
				r = 32767;
			end
			if (r < -32768) begin
				r = -32768;
			end
			return r[SAMPLE_W-1:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_VOICE_COUNT:  active_voices = data[3:0];
				REG_VOICE_INDEX:  sel_voice = data[2:0];
				REG_PHASE_STEP:   phase_step[sel_voice] = data;
				REG_PHASE_OFFSET: phase_offset[sel_voice] = data;
				REG_PAN:          pan_share[sel_voice] = data[16:0];
				default:          ;
			endcase
		endfunction

		// one accepted request: optional restart, then its frames
		function void take_request(logic [6:0] frames_req, logic restart_req);
			int unsigned   frames;
			int unsigned   n;
			int unsigned   q;
			logic [16:0]   pan;
			logic [31:0]   ph;
			longint        s;
			longint        lsum;
			longint        rsum;
			stereo_frame_t fr;
			if (restart_req) begin
				for (int unsigned v = 0; v < VOICES; v++) begin
					phase_acc[v] = '0;
				end
			end
			frames = (frames_req > BURST_CAP) ? BURST_CAP : frames_req;
			n      = (active_voices > VOICES) ? VOICES : active_voices;
			for (int unsigned f = 0; f < frames; f++) begin
				lsum = 0;
				rsum = 0;
				for (int unsigned v = 0; v < n; v++) begin
					pan = (pan_share[v] > PAN_ONE) ? PAN_ONE : pan_share[v];
					ph  = phase_acc[v] + phase_offset[v];
					q   = ph[29 -: TBL_BITS];
					s   = ph[30] ? sine_quarter[TBL_N - q] : sine_quarter[q];
					if (ph[31]) begin
						s = -s;
					end
					lsum += s * longint'(pan);
					rsum += s * longint'(65536 - int'(pan));
				end
				if (n > 0) begin
					fr.left  = scale_to_sample(lsum, n);
					fr.right = scale_to_sample(rsum, n);
				end else begin
					fr.left  = '0;
					fr.right = '0;
				end
				fr.last = (f + 1 == frames);
				pending_frames.push_back(fr);
				for (int unsigned v = 0; v < VOICES; v++) begin
					phase_acc[v] = phase_acc[v] + phase_step[v];
				end
			end
		endfunction

		function void note_failure(string msg);
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("%s", msg);
			end
		endfunction

		function void check_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
				logic lst);
			stereo_frame_t exp_fr;
			if (pending_frames.size() == 0) begin
				note_failure($sformatf("unexpected frame: l=%0d r=%0d last=%0b",
					$signed(l), $signed(r), lst));
				return;
			end
			exp_fr = pending_frames.pop_front();
			if (l !== exp_fr.left || r !== exp_fr.right || lst !== exp_fr.last) begin
				note_failure($sformatf(
					"frame mismatch: expected l=%0d r=%0d last=%0b, got l=%0d r=%0d last=%0b",
					exp_fr.left, exp_fr.right, exp_fr.last, $signed(l), $signed(r), lst));
			end
		endfunction
	endclass

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [CFG_W-1:0]           cfg_wdata    = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [6:0]                 frame_count  = '0;
	logic                       restart      = 1'b0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       last_frame;

	mixer_frame_checker board;
	bit                 gaps_on      = 1'b0;
	int unsigned        burst_left   = 0;
	bit                 hold_off_due = 1'b0;
	longint             cycle_count  = 0;

	multi_voice_sine_pan_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_count  (frame_count),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_frame   (last_frame)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// frame channel monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_frame(left_sample, right_sample, last_frame);
		end
	end

	// frame channel stall pattern, with a long hold-off on request
	initial begin : receiver_pattern
		int unsigned mode;
		int unsigned run;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run  = $urandom_range(20, 200);
			repeat (run) begin
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= $urandom_range(0, 1);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_voice(input logic [CFG_W-1:0] idx_word, input logic [31:0] step,
			input logic [31:0] offset, input logic [CFG_W-1:0] pan_word);
		write_cfg(REG_VOICE_INDEX, idx_word);
		write_cfg(REG_PHASE_STEP, step);
		write_cfg(REG_PHASE_OFFSET, offset);
		write_cfg(REG_PAN, pan_word);
	endtask

	// offer one request, with a random gap between bursts
	task automatic offer_request(input logic [6:0] fc, input logic rs);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		frame_count <= fc;
		restart     <= rs;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.take_request(fc, rs);
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	// wait for every owed frame, then let a trailing restart settle
	task automatic drain_phase();
		in_valid <= 1'b0;
		while (board.pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [6:0] pick_frames();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			return 7'd0;
		end else if (roll < 85) begin
			return 7'($urandom_range(1, 8));
		end else if (roll < 95) begin
			return 7'($urandom_range(9, 63));
		end
		return 7'($urandom_range(64, 127));
	endfunction

	// new random voice settings between phases
	task automatic shuffle_voices();
		logic [31:0] junk;
		logic [31:0] step;
		logic [31:0] offset;
		logic [16:0] pan;
		logic [3:0]  count;
		int unsigned roll;
		for (int unsigned v = 0; v < VOICES; v++) begin
			if ($urandom_range(0, 1) == 0) begin
				continue;
			end
			case ($urandom_range(0, 5))
				0:       step = $urandom();
				1, 2:    step = $urandom_range(20, 20000) * HZ_TO_STEP;
				3:       step = 32'd0;
				4:       step = 32'hFFFF_FFFF;
				default: step = 32'd1 << $urandom_range(0, 31);
			endcase
			case ($urandom_range(0, 3))
				0:       offset = 32'd0;
				1:       offset = 32'hFFFF_FFFF;
				default: offset = $urandom();
			endcase
			case ($urandom_range(0, 5))
				0:       pan = 17'd0;
				1:       pan = PAN_ONE;
				2:       pan = 17'($urandom_range(65537, 131071));
				default: pan = 17'($urandom_range(0, 65536));
			endcase
			junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
			set_voice({junk[31:3], 3'(v)}, step, offset, {junk[31:17], pan});
		end
		if ($urandom_range(0, 2) == 0) begin
			write_cfg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
		end
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			count = 4'd0;
		end else if (roll == 1) begin
			count = 4'($urandom_range(9, 15));
		end else begin
			count = 4'($urandom_range(1, 8));
		end
		junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
		write_cfg(REG_VOICE_COUNT, {junk[31:4], count});
	endtask

	initial begin : stimulus
		logic [31:0] dir_step   [VOICES];
		logic [31:0] dir_offset [VOICES];
		logic [16:0] dir_pan    [VOICES];
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no voices, silent frames and a bare restart
		offer_request(7'd1, 1'b0);
		offer_request(7'd0, 1'b1);
		drain_phase();

		// one full-left voice, 64 frames per turn, overlong bursts
		write_cfg(REG_VOICE_COUNT, 32'd1);
		set_voice(32'd0, 32'h0400_0000, 32'd0, {15'd0, PAN_ONE});
		offer_request(7'd64, 1'b1);
		offer_request(7'd100, 1'b0);
		offer_request(7'd127, 1'b1);
		drain_phase();

		// all eight voices with extreme steps, offsets and pans
		dir_step   = '{32'd0, 32'hFFFF_FFFF, 32'h0400_0000, 32'd1,
			32'h8000_0000, 32'd440 * HZ_TO_STEP, 32'h0010_0000, 32'h7FFF_FFFF};
		dir_offset = '{32'h4000_0000, 32'hFFFF_FFFF, 32'd0, 32'hC000_0000,
			32'h8000_0000, 32'd0, 32'h3FF0_0000, 32'h1234_5678};
		dir_pan    = '{PAN_ONE, 17'd0, 17'h1FFFF, 17'd32768,
			17'd0, PAN_ONE, 17'd1, 17'd65535};
		write_cfg(REG_VOICE_COUNT, 32'd8);
		for (int unsigned v = 0; v < VOICES; v++) begin
			set_voice(32'(v), dir_step[v], dir_offset[v], {15'd0, dir_pan[v]});
		end
		offer_request(7'd16, 1'b1);
		offer_request(7'd5, 1'b0);
		offer_request(7'd0, 1'b0);
		offer_request(7'd3, 1'b1);
		drain_phase();

		// oversized count, spare registers, step changed without restart
		write_cfg(REG_VOICE_COUNT, 32'hFFFF_FFFF);
		for (int unsigned i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
			write_cfg(3'(i), 32'hFFFF_FFFF);
		end
		write_cfg(REG_VOICE_INDEX, 32'hFFFF_FFF8);
		write_cfg(REG_PHASE_STEP, 32'h0123_4567);
		offer_request(7'd2, 1'b0);
		offer_request(7'd1, 1'b1);
		offer_request(7'd64, 1'b0);
		drain_phase();

		// count written back to zero
		write_cfg(REG_VOICE_COUNT, 32'd0);
		offer_request(7'd4, 1'b0);
		drain_phase();

		// random phases
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			gaps_on    = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			shuffle_voices();
			if (p == 1 || p == 7) begin
				hold_off_due = 1'b1;
			end
			for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
				offer_request(pick_frames(), $urandom_range(0, 3) == 0);
			end
			drain_phase();
		end

		if (board.pending_frames.size() != 0) begin
			$display("%0d expected frames never arrived", board.pending_frames.size());
		end
		if (board.fail_count == 0 && board.pending_frames.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
